// ===== design/wncs_pkg.sv =====
// Shared types and constants of the windowed natural cubic spline evaluator.
`default_nettype none

package wncs_pkg;

   // Request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   // Field widths fixed by the interface
   localparam int TIME_W  = 10;
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 3;
   localparam int COUNT_W = 4;

   localparam logic [COUNT_W-1:0] KNOT_COUNT_RESET = 4'd3;

   // Arithmetic widths of the evaluation path
   localparam int NUMW = 78;   // signed numerator of one cubic piece
   localparam int DVW  = 78;   // dividend / quotient shift register
   localparam int DENW = 42;   // denominator hs*g
   localparam int DSRW = 43;   // doubled denominator, also remainder width

   // Largest quotient the rounding step keeps
   localparam logic [40:0] Q_LIMIT = 41'h100_0000_0000;

   typedef struct packed {
      logic                      req_type;
      logic [INDEX_W-1:0]        knot_index;
      logic [TIME_W-1:0]         knot_time;
      logic signed [VALUE_W-1:0] knot_value;
      logic [TIME_W-1:0]         query_time;
   } wncs_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] spline_value;
      logic                      in_range;
      logic                      bad_knots;
   } wncs_rsp_type;

   // Datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NOP,
      OP_RD,
      OP_CHK,
      OP_SETW,
      OP_GET_A,
      OP_GET_B,
      OP_GET_C,
      OP_C1,
      OP_C2,
      OP_C3,
      OP_C4,
      OP_MA_LO,
      OP_MA_HI,
      OP_SUM_A,
      OP_MB_LO,
      OP_MB_HI,
      OP_SUM_B1,
      OP_SUM_B2,
      OP_ABS,
      OP_PREP,
      OP_DIV,
      OP_FINISH,
      OP_ZERO,
      OP_PUSH
   } wncs_op_type;

   typedef struct packed {
      wncs_op_type op;
   } wncs_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic div_last;
      logic bad;
      logic in_range;
      logic out_free;
   } wncs_status_type;

endpackage

`default_nettype wire

// ===== design/wncs_ctrl.sv =====
// Sequencer that steps the datapath through knot scan, fetch, math and divide.
`default_nettype none

module wncs_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        query_start,
   input  wncs_pkg::wncs_status_type  status,
   output wncs_pkg::wncs_cmd_type     cmd,
   output logic                       idle
);
   import wncs_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_SRD, S_SCHK, S_DECIDE, S_ZERO, S_SETW,
      S_FRD0, S_FGA, S_FRD1, S_FGB, S_FRD2, S_FGC,
      S_C1, S_C2, S_C3, S_C4,
      S_MALO, S_MAHI, S_SUMA, S_MBLO, S_MBHI, S_SUMB1, S_SUMB2,
      S_ABS, S_PREP, S_DIV, S_FIN, S_OUT
   } state_type;

   state_type    state_ff;
   wncs_cmd_type cmd_ff;
   logic         idle_ff;

   // State, the operation for the coming cycle and the idle flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cmd_ff.op <= OP_NOP;
         idle_ff   <= 1'b1;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (query_start) begin
                  state_ff <= S_SRD; cmd_ff.op <= OP_RD; idle_ff <= 1'b0;
               end else begin
                  cmd_ff.op <= OP_NOP;
               end
            end
            S_SRD: begin state_ff <= S_SCHK; cmd_ff.op <= OP_CHK; end
            S_SCHK: begin
               if (status.scan_last) begin
                  state_ff <= S_DECIDE; cmd_ff.op <= OP_NOP;
               end else begin
                  state_ff <= S_SRD; cmd_ff.op <= OP_RD;
               end
            end
            S_DECIDE: begin
               if (status.bad || !status.in_range) begin
                  state_ff <= S_ZERO; cmd_ff.op <= OP_ZERO;
               end else begin
                  state_ff <= S_SETW; cmd_ff.op <= OP_SETW;
               end
            end
            S_ZERO:  begin state_ff <= S_OUT;   cmd_ff.op <= OP_PUSH;   end
            S_SETW:  begin state_ff <= S_FRD0;  cmd_ff.op <= OP_RD;     end
            S_FRD0:  begin state_ff <= S_FGA;   cmd_ff.op <= OP_GET_A;  end
            S_FGA:   begin state_ff <= S_FRD1;  cmd_ff.op <= OP_RD;     end
            S_FRD1:  begin state_ff <= S_FGB;   cmd_ff.op <= OP_GET_B;  end
            S_FGB:   begin state_ff <= S_FRD2;  cmd_ff.op <= OP_RD;     end
            S_FRD2:  begin state_ff <= S_FGC;   cmd_ff.op <= OP_GET_C;  end
            S_FGC:   begin state_ff <= S_C1;    cmd_ff.op <= OP_C1;     end
            S_C1:    begin state_ff <= S_C2;    cmd_ff.op <= OP_C2;     end
            S_C2:    begin state_ff <= S_C3;    cmd_ff.op <= OP_C3;     end
            S_C3:    begin state_ff <= S_C4;    cmd_ff.op <= OP_C4;     end
            S_C4:    begin state_ff <= S_MALO;  cmd_ff.op <= OP_MA_LO;  end
            S_MALO:  begin state_ff <= S_MAHI;  cmd_ff.op <= OP_MA_HI;  end
            S_MAHI:  begin state_ff <= S_SUMA;  cmd_ff.op <= OP_SUM_A;  end
            S_SUMA:  begin state_ff <= S_MBLO;  cmd_ff.op <= OP_MB_LO;  end
            S_MBLO:  begin state_ff <= S_MBHI;  cmd_ff.op <= OP_MB_HI;  end
            S_MBHI:  begin state_ff <= S_SUMB1; cmd_ff.op <= OP_SUM_B1; end
            S_SUMB1: begin state_ff <= S_SUMB2; cmd_ff.op <= OP_SUM_B2; end
            S_SUMB2: begin state_ff <= S_ABS;   cmd_ff.op <= OP_ABS;    end
            S_ABS:   begin state_ff <= S_PREP;  cmd_ff.op <= OP_PREP;   end
            S_PREP:  begin state_ff <= S_DIV;   cmd_ff.op <= OP_DIV;    end
            S_DIV: begin
               if (status.div_last) begin
                  state_ff <= S_FIN; cmd_ff.op <= OP_FINISH;
               end else begin
                  cmd_ff.op <= OP_DIV;
               end
            end
            S_FIN: begin state_ff <= S_OUT; cmd_ff.op <= OP_PUSH; end
            S_OUT: begin
               // leave once the output register takes the result
               if (status.out_free) begin
                  state_ff <= S_IDLE; cmd_ff.op <= OP_NOP; idle_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE; cmd_ff.op <= OP_NOP; idle_ff <= 1'b1;
            end
         endcase
      end
   end

   assign cmd  = cmd_ff;
   assign idle = idle_ff;

endmodule

`default_nettype wire

// ===== design/wncs_dp.sv =====
// Datapath: knot store, segment search, cubic piece math, divider, output register.
`default_nettype none

module wncs_dp #(
   parameter int MAX_KNOTS = 8,
   parameter int TIME_SPAN = 1024
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_accept,
   input  wncs_pkg::wncs_req_type     req_data,
   input  wire                        csr_wr_en,
   input  wire [wncs_pkg::COUNT_W-1:0] csr_wr_data,
   input  wncs_pkg::wncs_cmd_type     cmd,
   output wncs_pkg::wncs_status_type  status,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output wncs_pkg::wncs_rsp_type     rsp_data
);
   import wncs_pkg::*;

   localparam int AW  = $clog2(MAX_KNOTS);
   localparam int CW  = $clog2(MAX_KNOTS + 1);
   localparam int DCW = $clog2(DVW);

   // Knot store
   logic [TIME_W-1:0]         knot_t_mem [MAX_KNOTS];
   logic signed [VALUE_W-1:0] knot_y_mem [MAX_KNOTS];
   logic [TIME_W-1:0]         rd_t_ff;
   logic signed [VALUE_W-1:0] rd_y_ff;
   logic [AW-1:0]             wr_addr;

   logic [COUNT_W-1:0] knot_count_ff;
   logic [CW-1:0]      cnt_clamp;

   // Scan state
   logic [TIME_W-1:0] t_ff, t_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              span_ok_ff, span_ok_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     j_ff, j_in;
   logic [TIME_W-1:0] prev_t_ff, prev_t_in;
   logic              bad_ff, bad_in, lo_ok_ff, lo_ok_in, hi_ok_ff, hi_ok_in;
   logic              right_ff, right_in;

   // Window knots and piece terms
   logic [TIME_W-1:0]         ta_ff, ta_in, tb_ff, tb_in, tc_ff, tc_in;
   logic signed [VALUE_W-1:0] ya_ff, ya_in, yb_ff, yb_in, yc_ff, yc_in;
   logic [TIME_W-1:0]         h0_ff, h0_in, h1_ff, h1_in, hs_ff, hs_in;
   logic signed [32:0]        dy0_ff, dy0_in, dy1_ff, dy1_in, d_ff, d_in;
   logic signed [10:0]        z_ff, z_in;
   logic signed [42:0]        p0_ff, p0_in, p1_ff, p1_in;
   logic signed [VALUE_W-1:0] base_ff, base_in;
   logic [19:0]               hsq_ff, hsq_in, hpo_ff, hpo_in;
   logic [20:0]               zsq_ff, zsq_in;
   logic [10:0]               hsum_ff, hsum_in;
   logic signed [44:0]        ks_ff, ks_in;
   logic signed [43:0]        zd_ff, zd_in;
   logic [31:0]               g_ff, g_in;
   logic signed [21:0]        dq_ff, dq_in;
   logic [DENW-1:0]           den_ff, den_in;
   logic signed [32:0]        zw_ff, zw_in;
   logic signed [56:0]        mlo_ff, mlo_in;
   logic signed [55:0]        mhi_ff, mhi_in;
   logic signed [NUMW-1:0]    acc_ff, acc_in, num_ff, num_in;
   logic [NUMW-1:0]           mag_ff, mag_in;
   logic                      neg_ff, neg_in;

   // Divider
   logic [DVW-1:0]  dvd_ff, dvd_in;
   logic [DSRW-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DCW-1:0]  div_cnt_ff, div_cnt_in;

   wncs_rsp_type res_ff, res_in;
   wncs_rsp_type rsp_data_ff;
   logic         rsp_valid_ff;
   logic         out_free;

   // Combinational helpers
   logic [TIME_W-1:0]  hs_sel, ho_sel;
   logic signed [21:0] zsq_w;
   logic [30:0]        g_half_w;
   logic signed [55:0] pa_lo_w;
   logic signed [54:0] pa_hi_w;
   logic signed [56:0] pb_lo_w;
   logic signed [55:0] pb_hi_w;
   logic [DSRW:0]      div_try_w;
   logic               div_ge_w;
   logic [40:0]        q_w;
   logic signed [42:0] sum_w;
   logic [VALUE_W-1:0] sat_w;
   logic [CW-1:0]      idx_ext;

   assign wr_addr = AW'(req_data.knot_index);
   assign idx_ext = CW'(idx_ff);

   // Knot count clamped to the usable range
   always_comb begin
      if (knot_count_ff < 4'd3) cnt_clamp = CW'(3);
      else if (32'(knot_count_ff) > MAX_KNOTS) cnt_clamp = CW'(MAX_KNOTS);
      else cnt_clamp = CW'(knot_count_ff);
   end

   assign hs_sel   = right_ff ? h1_ff : h0_ff;
   assign ho_sel   = right_ff ? h0_ff : h1_ff;
   assign zsq_w    = 22'(z_ff) * 22'(z_ff);
   assign g_half_w = 31'(hpo_ff) * 31'(hsum_ff);
   assign pa_lo_w  = 56'($signed({1'b0, zd_ff[21:0]})) * 56'($signed({1'b0, g_ff}));
   assign pa_hi_w  = 55'($signed(zd_ff[43:22])) * 55'($signed({1'b0, g_ff}));
   assign pb_lo_w  = 57'($signed({1'b0, ks_ff[22:0]})) * 57'(zw_ff);
   assign pb_hi_w  = 56'($signed(ks_ff[44:23])) * 56'(zw_ff);

   // One restoring divide step
   assign div_try_w = {rem_ff, dvd_ff[DVW-1]};
   assign div_ge_w  = div_try_w >= {1'b0, dsr_ff};

   // Rounded quotient clamp, signed add and saturation
   assign q_w   = (dvd_ff > {{(DVW-41){1'b0}}, Q_LIMIT}) ? Q_LIMIT : dvd_ff[40:0];
   assign sum_w = neg_ff ? ($signed({{11{base_ff[31]}}, base_ff}) - $signed({2'b0, q_w}))
                         : ($signed({{11{base_ff[31]}}, base_ff}) + $signed({2'b0, q_w}));
   always_comb begin
      if (sum_w[42:31] == '0 || sum_w[42:31] == '1) sat_w = sum_w[31:0];
      else if (sum_w[42]) sat_w = 32'h8000_0000;
      else sat_w = 32'h7FFF_FFFF;
   end

   // Next-state of the datapath registers
   always_comb begin
      t_in = t_ff; cnt_in = cnt_ff; span_ok_in = span_ok_ff;
      idx_in = idx_ff; j_in = j_ff; prev_t_in = prev_t_ff;
      bad_in = bad_ff; lo_ok_in = lo_ok_ff; hi_ok_in = hi_ok_ff; right_in = right_ff;
      ta_in = ta_ff; tb_in = tb_ff; tc_in = tc_ff;
      ya_in = ya_ff; yb_in = yb_ff; yc_in = yc_ff;
      h0_in = h0_ff; h1_in = h1_ff; hs_in = hs_ff;
      dy0_in = dy0_ff; dy1_in = dy1_ff; d_in = d_ff; z_in = z_ff;
      p0_in = p0_ff; p1_in = p1_ff; base_in = base_ff;
      hsq_in = hsq_ff; hpo_in = hpo_ff; zsq_in = zsq_ff; hsum_in = hsum_ff;
      ks_in = ks_ff; zd_in = zd_ff; g_in = g_ff; dq_in = dq_ff;
      den_in = den_ff; zw_in = zw_ff; mlo_in = mlo_ff; mhi_in = mhi_ff;
      acc_in = acc_ff; num_in = num_ff; mag_in = mag_ff; neg_in = neg_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; dsr_in = dsr_ff; div_cnt_in = div_cnt_ff;
      res_in = res_ff;
      unique case (cmd.op)
         OP_CHK: begin
            // ordering check, range ends and segment count
            if (idx_ff != '0 && prev_t_ff >= rd_t_ff) bad_in = 1'b1;
            if (idx_ff == '0) lo_ok_in = t_ff >= rd_t_ff;
            if (idx_ext == cnt_ff - CW'(1)) hi_ok_in = t_ff < rd_t_ff;
            if (idx_ff != '0 && idx_ext < cnt_ff - CW'(1) && rd_t_ff <= t_ff)
               j_in = j_ff + 1'b1;
            prev_t_in = rd_t_ff;
            idx_in = idx_ff + 1'b1;
         end
         OP_SETW: begin
            // the last segment uses the right piece of the final window
            if (CW'(j_ff) == cnt_ff - CW'(2)) begin
               right_in = 1'b1;
               idx_in = AW'(cnt_ff - CW'(3));
            end else begin
               right_in = 1'b0;
               idx_in = j_ff;
            end
         end
         OP_GET_A: begin ta_in = rd_t_ff; ya_in = rd_y_ff; idx_in = idx_ff + 1'b1; end
         OP_GET_B: begin tb_in = rd_t_ff; yb_in = rd_y_ff; idx_in = idx_ff + 1'b1; end
         OP_GET_C: begin tc_in = rd_t_ff; yc_in = rd_y_ff; end
         OP_C1: begin
            h0_in  = tb_ff - ta_ff;
            h1_in  = tc_ff - tb_ff;
            dy0_in = 33'(yb_ff) - 33'(ya_ff);
            dy1_in = 33'(yc_ff) - 33'(yb_ff);
            z_in   = right_ff ? ($signed({1'b0, t_ff}) - $signed({1'b0, tc_ff}))
                              : ($signed({1'b0, t_ff}) - $signed({1'b0, ta_ff}));
         end
         OP_C2: begin
            p0_in   = 43'($signed({1'b0, h0_ff})) * 43'(dy1_ff);
            p1_in   = 43'($signed({1'b0, h1_ff})) * 43'(dy0_ff);
            hs_in   = hs_sel;
            d_in    = right_ff ? dy1_ff : dy0_ff;
            base_in = right_ff ? yc_ff : ya_ff;
            hsq_in  = 20'(hs_sel) * 20'(hs_sel);
            hpo_in  = 20'(hs_sel) * 20'(ho_sel);
            hsum_in = {1'b0, hs_sel} + {1'b0, ho_sel};
            zsq_in  = zsq_w[20:0];
         end
         OP_C3: begin
            ks_in = right_ff ? (45'(p1_ff) - 45'(p0_ff)) : (45'(p0_ff) - 45'(p1_ff));
            zd_in = 44'(z_ff) * 44'(d_ff);
            g_in  = {g_half_w, 1'b0};
            dq_in = $signed({1'b0, zsq_ff}) - $signed({2'b0, hsq_ff});
         end
         OP_C4: begin
            den_in = DENW'(hs_ff) * DENW'(g_ff);
            zw_in  = 33'(z_ff) * 33'(dq_ff);
         end
         OP_MA_LO: mlo_in = 57'(pa_lo_w);
         OP_MA_HI: mhi_in = 56'(pa_hi_w);
         OP_SUM_A: acc_in = ({{(NUMW-56){mhi_ff[55]}}, mhi_ff} << 22)
                            + {{(NUMW-57){mlo_ff[56]}}, mlo_ff};
         OP_MB_LO: mlo_in = pb_lo_w;
         OP_MB_HI: mhi_in = pb_hi_w;
         OP_SUM_B1: num_in = ({{(NUMW-56){mhi_ff[55]}}, mhi_ff} << 23)
                             + {{(NUMW-57){mlo_ff[56]}}, mlo_ff};
         OP_SUM_B2: num_in = num_ff + acc_ff;
         OP_ABS: begin
            neg_in = num_ff[NUMW-1];
            mag_in = num_ff[NUMW-1] ? (~num_ff + 1'b1) : num_ff;
         end
         OP_PREP: begin
            // round to nearest: (2*|num| + den) / (2*den)
            dvd_in     = {mag_ff[NUMW-2:0], 1'b0} + DVW'(den_ff);
            rem_in     = '0;
            dsr_in     = {den_ff, 1'b0};
            div_cnt_in = DCW'(DVW - 1);
         end
         OP_DIV: begin
            rem_in     = div_ge_w ? DSRW'(div_try_w - {1'b0, dsr_ff}) : div_try_w[DSRW-1:0];
            dvd_in     = {dvd_ff[DVW-2:0], div_ge_w};
            div_cnt_in = div_cnt_ff - 1'b1;
         end
         OP_FINISH: begin
            res_in.spline_value = sat_w;
            res_in.in_range     = 1'b1;
            res_in.bad_knots    = 1'b0;
         end
         OP_ZERO: begin
            res_in.spline_value = '0;
            res_in.in_range     = 1'b0;
            res_in.bad_knots    = bad_ff;
         end
         default: ;
      endcase
      // a new query restarts the scan
      if (req_accept && req_data.req_type == REQ_EVAL) begin
         t_in       = req_data.query_time;
         cnt_in     = cnt_clamp;
         span_ok_in = 32'(req_data.query_time) < TIME_SPAN;
         idx_in     = '0;
         j_in       = '0;
         bad_in     = 1'b0;
         lo_ok_in   = 1'b0;
         hi_ok_in   = 1'b0;
      end
   end

   // Control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         knot_count_ff <= KNOT_COUNT_RESET;
      end else if (csr_wr_en) begin
         knot_count_ff <= csr_wr_data;
      end
      t_ff <= t_in; cnt_ff <= cnt_in; span_ok_ff <= span_ok_in;
      idx_ff <= idx_in; j_ff <= j_in; prev_t_ff <= prev_t_in;
      bad_ff <= bad_in; lo_ok_ff <= lo_ok_in; hi_ok_ff <= hi_ok_in; right_ff <= right_in;
      ta_ff <= ta_in; tb_ff <= tb_in; tc_ff <= tc_in;
      ya_ff <= ya_in; yb_ff <= yb_in; yc_ff <= yc_in;
      h0_ff <= h0_in; h1_ff <= h1_in; hs_ff <= hs_in;
      dy0_ff <= dy0_in; dy1_ff <= dy1_in; d_ff <= d_in; z_ff <= z_in;
      p0_ff <= p0_in; p1_ff <= p1_in; base_ff <= base_in;
      hsq_ff <= hsq_in; hpo_ff <= hpo_in; zsq_ff <= zsq_in; hsum_ff <= hsum_in;
      ks_ff <= ks_in; zd_ff <= zd_in; g_ff <= g_in; dq_ff <= dq_in;
      den_ff <= den_in; zw_ff <= zw_in; mlo_ff <= mlo_in; mhi_ff <= mhi_in;
      acc_ff <= acc_in; num_ff <= num_in; mag_ff <= mag_in; neg_ff <= neg_in;
      dvd_ff <= dvd_in; rem_ff <= rem_in; dsr_ff <= dsr_in; div_cnt_ff <= div_cnt_in;
      res_ff <= res_in;
   end

   // Knot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req_accept && req_data.req_type == REQ_LOAD
          && 32'(req_data.knot_index) < MAX_KNOTS) begin
         knot_t_mem[wr_addr] <= req_data.knot_time;
         knot_y_mem[wr_addr] <= req_data.knot_value;
      end
      if (cmd.op == OP_RD) begin
         rd_t_ff <= knot_t_mem[idx_ff];
         rd_y_ff <= knot_y_mem[idx_ff];
      end
   end

   // Output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_PUSH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_PUSH && out_free) rsp_data_ff <= res_ff;
   end

   assign status.scan_last = idx_ext == cnt_ff - CW'(1);
   assign status.div_last  = div_cnt_ff == '0;
   assign status.bad       = bad_ff;
   assign status.in_range  = lo_ok_ff && hi_ok_ff && span_ok_ff;
   assign status.out_free  = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.in_range && rsp_data_ff.bad_knots))
      else $error("result both in range and bad");
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.in_range) |-> rsp_data_ff.spline_value == '0)
      else $error("out of range result not zero");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_DIV |-> rem_ff < dsr_ff)
      else $error("divider remainder not below divisor");
   a_push: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUSH && out_free) |=> rsp_valid_ff)
      else $error("pushed result not shown");

endmodule

`default_nettype wire

// ===== design/windowed_natural_cubic_spline_eval_core.sv =====
// Top level of the windowed natural cubic spline evaluator.
// Requests arrive on req_valid/req_stall with req_data. A load request
// writes one knot (time, Q16.16 value) into its slot; it gives no result.
// An evaluate request scans the knots, picks the three-knot window of the
// query's segment and evaluates the cubic piece, giving one result on
// rsp_valid/rsp_stall with rsp_data.
// An in-range evaluate reads each knot for the scan through the knot
// memory's one registered read port, then runs eleven steps of piece math
// and a bit-serial restoring divider. Out-of-range or unordered-knot
// queries skip the window fetch, math and divide. One request is worked
// at a time; req_stall is high from an evaluate's acceptance until its
// result has been moved into the output register.
// The output register holds a finished result while rsp_stall is high, and
// the next request is accepted during that wait. csr_wr_en/csr_wr_data set
// knot_count; the user must do so only while the block is idle, which the
// block itself does not enforce.
// Reset clears the control state, sets knot_count to 3 and empties the
// output register; knot slots hold no defined value until loaded.
`default_nettype none

module windowed_natural_cubic_spline_eval_core #(
   parameter int MAX_KNOTS = 8,
   parameter int TIME_SPAN = 1024
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wncs_pkg::wncs_req_type      req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output wncs_pkg::wncs_rsp_type      rsp_data,
   input  wire                         csr_wr_en,
   input  wire [wncs_pkg::COUNT_W-1:0] csr_wr_data
);
   import wncs_pkg::*;

   wncs_cmd_type    cmd;
   wncs_status_type status;
   logic            idle;
   logic            req_accept;
   logic            query_start;

   assign req_stall   = !idle;
   assign req_accept  = req_valid && idle;
   assign query_start = req_accept && req_data.req_type == REQ_EVAL;

   wncs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .query_start (query_start),
      .status      (status),
      .cmd         (cmd),
      .idle        (idle)
   );

   wncs_dp #(
      .MAX_KNOTS (MAX_KNOTS),
      .TIME_SPAN (TIME_SPAN)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
